// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Defining ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)

`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

// ===== rtl/core/nca_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest centroid assignment package
// Sizes, codes and shared types of the nearest centroid assignment core.
// ----------------------------------------------------------------------------
package nca_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_DIM      = 64;
  localparam int ELEMENT_BITS = 16;

  localparam int CL_W      = $clog2(MAX_CLUSTERS);
  localparam int DIM_W     = $clog2(MAX_DIM);
  localparam int ADDR_W    = CL_W + DIM_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int DIFF_W    = ELEMENT_BITS + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int DIST_W    = 42;

  localparam int AC_W       = 5;
  localparam int VL_W       = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CLUSTERS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH   = CFG_IDX_W'(1);

  typedef logic signed [ELEMENT_BITS-1:0] nca_elem_t;
  typedef logic [DIST_W-1:0] nca_dist_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } nca_state_t;

  typedef struct packed {
    logic            vld;
    logic            lst;
    logic [CL_W-1:0] clu;
  } nca_step_t;

endpackage

// ===== rtl/core/nca_intf.sv =====
// ----------------------------------------------------------------------------
// Nearest centroid assignment channels
// Valid/ready channels for query and load elements, results and register writes.
// ----------------------------------------------------------------------------
interface nca_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [nca_pkg::CL_W-1:0]      cluster_index;
  logic [nca_pkg::DIM_W-1:0]     element_index;
  logic signed [15:0]            element_value;

  modport source (output valid, opcode, cluster_index, element_index, element_value,
                  input ready);
  modport sink (input valid, opcode, cluster_index, element_index, element_value,
                output ready);
endinterface

interface nca_out_if;
  logic                       valid;
  logic                       ready;
  logic [nca_pkg::CL_W-1:0]   nearest_label;
  logic [nca_pkg::DIST_W-1:0] best_distance;

  modport source (output valid, nearest_label, best_distance, input ready);
  modport sink (input valid, nearest_label, best_distance, output ready);
endinterface

interface nca_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nca_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [nca_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/core/nearest_centroid_assign_core.sv =====
// ----------------------------------------------------------------------------
// Nearest centroid assignment core: load elements, and query elements beyond
// the vector length, are taken while idle and start no work; any other query
// element is processed against each of the K active centroids before the next
// is accepted, paced by the centroid memory read port and the shared
// subtract-square unit, and the last element also waits for a full result register to drain.
// Synchronous active-low reset clears accumulators and sets K=16, length=64.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_centroid_assign_core (
  input  logic      clk,
  input  logic      rst_n,
  nca_in_if.sink    in_chan,
  nca_out_if.source out_chan,
  nca_cfg_if.sink   cfg_chan
);
  import nca_pkg::*;

  nca_state_t      state_r, state_nxt;
  logic [AC_W-1:0] active_clusters_r, active_clusters_nxt;
  logic [VL_W-1:0] vector_length_r, vector_length_nxt;
  nca_elem_t       q_val_r;
  logic [DIM_W-1:0] q_ei_r;
  logic            first_r, emit_r;
  logic [CL_W-1:0] kmax_r, kmax_eff;
  logic [DIM_W-1:0] lmax_eff;
  logic [CL_W-1:0] issue_c_r, issue_c_nxt;
  nca_step_t       rd_step_r, issue_step, term_step;
  logic            out_valid_r, out_valid_nxt;
  logic [CL_W-1:0] out_label_r;
  nca_dist_t       out_dist_r;

  logic            in_acc, cfg_acc, load_wr, q_start, slot_free, out_load;
  logic            rd_en, done;
  logic [ADDR_W-1:0] rd_addr;
  nca_elem_t       rd_data;
  nca_dist_t       term, best_dist;
  logic [CL_W-1:0] best_label;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign cfg_acc = cfg_chan.valid && cfg_chan.ready;
  assign load_wr = in_acc && (in_chan.opcode == OP_LOAD);
  assign q_start = in_acc && (in_chan.opcode == OP_QUERY)
                && (in_chan.element_index <= lmax_eff);
  assign slot_free = !out_valid_r || out_chan.ready;

  always_comb begin
    if (active_clusters_r == '0) begin
      kmax_eff = '0;
    end else if (int'(active_clusters_r) > MAX_CLUSTERS) begin
      kmax_eff = CL_W'(MAX_CLUSTERS - 1);
    end else begin
      kmax_eff = CL_W'(active_clusters_r - AC_W'(1));
    end
    if (vector_length_r == '0) begin
      lmax_eff = '0;
    end else if (int'(vector_length_r) > MAX_DIM) begin
      lmax_eff = DIM_W'(MAX_DIM - 1);
    end else begin
      lmax_eff = DIM_W'(vector_length_r - VL_W'(1));
    end
  end

  always_comb begin
    active_clusters_nxt = active_clusters_r;
    vector_length_nxt   = vector_length_r;
    if (cfg_acc) begin
      unique case (cfg_chan.reg_index)
        REG_ACTIVE_CLUSTERS: active_clusters_nxt = cfg_chan.wdata[AC_W-1:0];
        REG_VECTOR_LENGTH:   vector_length_nxt   = cfg_chan.wdata[VL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_start) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (issue_c_r == kmax_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!emit_r || slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_chan.ready = 1'b1;
      ST_RUN:    rd_en = 1'b1;
      ST_DRAIN: begin
      end
      ST_FINISH: out_load = emit_r && slot_free;
      default: begin
      end
    endcase
  end

  assign rd_addr        = {issue_c_r, q_ei_r};
  assign issue_step.vld = rd_en;
  assign issue_step.lst = (issue_c_r == kmax_r);
  assign issue_step.clu = issue_c_r;
  assign issue_c_nxt    = q_start ? '0 : (rd_en ? issue_c_r + CL_W'(1) : issue_c_r);
  assign out_valid_nxt  = out_load ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      active_clusters_r <= AC_W'(MAX_CLUSTERS);
      vector_length_r   <= VL_W'(MAX_DIM);
      issue_c_r         <= '0;
      rd_step_r         <= '0;
      out_valid_r       <= 1'b0;
      first_r           <= 1'b0;
      emit_r            <= 1'b0;
      kmax_r            <= '0;
    end else begin
      state_r           <= state_nxt;
      active_clusters_r <= active_clusters_nxt;
      vector_length_r   <= vector_length_nxt;
      issue_c_r         <= issue_c_nxt;
      rd_step_r         <= issue_step;
      out_valid_r       <= out_valid_nxt;
      if (q_start) begin
        first_r <= (in_chan.element_index == '0);
        emit_r  <= (in_chan.element_index == lmax_eff);
        kmax_r  <= kmax_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_start) begin
      q_val_r <= in_chan.element_value[ELEMENT_BITS-1:0];
      q_ei_r  <= in_chan.element_index;
    end
    if (out_load) begin
      out_label_r <= best_label;
      out_dist_r  <= best_dist;
    end
  end

  nca_centroid_mem u_mem (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr ({in_chan.cluster_index, in_chan.element_index}),
    .wr_data (in_chan.element_value[ELEMENT_BITS-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nca_dist_unit u_dist (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_in        (rd_step_r),
    .query_value    (q_val_r),
    .centroid_value (rd_data),
    .step_out       (term_step),
    .term           (term)
  );

  nca_acc_bank u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (term_step),
    .term       (term),
    .first_elem (first_r),
    .clear      (out_load),
    .done       (done),
    .best_label (best_label),
    .best_dist  (best_dist)
  );

  assign out_chan.valid         = out_valid_r;
  assign out_chan.nearest_label = out_label_r;
  assign out_chan.best_distance = out_dist_r;

  `ASSERT_IMPL(a_issue_in_range, clk, rst_n, state_r == ST_RUN, issue_c_r <= kmax_r,
               "centroid issue counter passed the active count")
  `ASSERT_IMPL(a_term_only_busy, clk, rst_n, term_step.vld,
               state_r == ST_RUN || state_r == ST_DRAIN,
               "distance term arrived outside a query pass")
  `ASSERT_NEXT(a_result_loaded, clk, rst_n, state_r == ST_FINISH && emit_r && slot_free,
               out_chan.valid && state_r == ST_IDLE,
               "finished query did not present its result")

endmodule

// ===== rtl/core/nca_centroid_mem.sv =====
// ----------------------------------------------------------------------------
// Centroid memory
// One write port and one registered read port over all centroid elements.
// ----------------------------------------------------------------------------
module nca_centroid_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [nca_pkg::ADDR_W-1:0] wr_addr,
  input  nca_pkg::nca_elem_t         wr_data,
  input  logic                       rd_en,
  input  logic [nca_pkg::ADDR_W-1:0] rd_addr,
  output nca_pkg::nca_elem_t         rd_data
);
  import nca_pkg::*;

  nca_elem_t mem_r [MEM_DEPTH];
  nca_elem_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/nca_dist_unit.sv =====
// ----------------------------------------------------------------------------
// Squared difference unit
// Two-stage pipeline: subtract, then square, one centroid element per cycle.
// ----------------------------------------------------------------------------
module nca_dist_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  nca_pkg::nca_step_t step_in,
  input  nca_pkg::nca_elem_t query_value,
  input  nca_pkg::nca_elem_t centroid_value,
  output nca_pkg::nca_step_t step_out,
  output nca_pkg::nca_dist_t term
);
  import nca_pkg::*;

  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  nca_step_t                s1_r, s2_r;

  assign diff_nxt = {query_value[ELEMENT_BITS-1], query_value}
                  - {centroid_value[ELEMENT_BITS-1], centroid_value};
  assign prod_nxt = diff_r * diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else begin
      s1_r <= step_in;
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    prod_r <= prod_nxt;
  end

  assign step_out = s2_r;
  assign term     = {{(DIST_W-PROD_W){1'b0}}, prod_r};

endmodule

// ===== rtl/core/nca_acc_bank.sv =====
// ----------------------------------------------------------------------------
// Distance accumulator bank
// Saturating per-centroid accumulators with a running nearest-centroid search.
// ----------------------------------------------------------------------------
module nca_acc_bank (
  input  logic                     clk,
  input  logic                     rst_n,
  input  nca_pkg::nca_step_t       step,
  input  nca_pkg::nca_dist_t       term,
  input  logic                     first_elem,
  input  logic                     clear,
  output logic                     done,
  output logic [nca_pkg::CL_W-1:0] best_label,
  output nca_pkg::nca_dist_t       best_dist
);
  import nca_pkg::*;

  nca_dist_t         acc_r [MAX_CLUSTERS];
  logic [DIST_W:0]   sum;
  nca_dist_t         upd;
  nca_dist_t         best_dist_r, best_dist_nxt;
  logic [CL_W-1:0]   best_label_r, best_label_nxt;

  always_comb begin
    sum = {1'b0, acc_r[step.clu]} + {1'b0, term};
    if (first_elem) begin
      upd = term;
    end else if (sum[DIST_W]) begin
      upd = DIST_MAX;
    end else begin
      upd = sum[DIST_W-1:0];
    end
  end

  always_comb begin
    best_dist_nxt  = best_dist_r;
    best_label_nxt = best_label_r;
    if (step.vld && ((step.clu == '0) || (upd < best_dist_r))) begin
      best_dist_nxt  = upd;
      best_label_nxt = step.clu;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        acc_r[i] <= '0;
      end
    end else if (step.vld) begin
      acc_r[step.clu] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    best_dist_r  <= best_dist_nxt;
    best_label_r <= best_label_nxt;
  end

  assign done       = step.vld && step.lst;
  assign best_label = best_label_r;
  assign best_dist  = best_dist_r;

endmodule

// ===== dv/nca_assign_monitor.sv =====
// ----------------------------------------------------------------------------
// Nearest centroid assignment monitor
// Watches the element, register and result channels of the core, keeps its
// own copy of the centroid table and distance sums, predicts each assignment
// and compares every result transaction field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module nca_assign_monitor (
  input  logic clk,
  input  logic rst_n,
  nca_in_if    in_mon,
  nca_out_if   out_mon,
  nca_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import nca_pkg::*;

  typedef struct packed {
    logic [CL_W-1:0] label;
    nca_dist_t       distance;
  } assignment_t;

  assignment_t     expected_assignments[$];
  nca_elem_t       centroid_copy[MAX_CLUSTERS][MAX_DIM];
  nca_dist_t       dist_sum[MAX_CLUSTERS];
  logic [AC_W-1:0] clusters_reg;
  logic [VL_W-1:0] length_reg;

  function automatic nca_dist_t squared_gap(nca_elem_t a, nca_elem_t b);
    longint gap;
    longint mag;
    gap = longint'(a) - longint'(b);
    mag = (gap < 0) ? -gap : gap;
    if (mag >= (longint'(1) << 21)) return DIST_MAX;
    if (mag * mag > longint'(DIST_MAX)) return DIST_MAX;
    return nca_dist_t'(mag * mag);
  endfunction

  function automatic nca_dist_t saturating_sum(nca_dist_t a, nca_dist_t b);
    logic [DIST_W:0] total;
    total = a + b;
    return total[DIST_W] ? DIST_MAX : total[DIST_W-1:0];
  endfunction

  task automatic apply_element(logic op, logic [CL_W-1:0] ci, logic [DIM_W-1:0] ei,
                               nca_elem_t value);
    int          k;
    int          len;
    nca_dist_t   term;
    assignment_t best;
    if (op == OP_LOAD) begin
      centroid_copy[ci][ei] = value;
      return;
    end
    k = (clusters_reg == 0) ? 1 : (clusters_reg > MAX_CLUSTERS) ? MAX_CLUSTERS
                                                                  : int'(clusters_reg);
    len = (length_reg == 0) ? 1 : (length_reg > MAX_DIM) ? MAX_DIM : int'(length_reg);
    if (int'(ei) >= len) return;
    for (int c = 0; c < k; c++) begin
      term = squared_gap(value, centroid_copy[c][ei]);
      dist_sum[c] = (ei == 0) ? term : saturating_sum(dist_sum[c], term);
    end
    if (int'(ei) != len - 1) return;
    best.label    = '0;
    best.distance = dist_sum[0];
    for (int c = 1; c < k; c++) begin
      if (dist_sum[c] < best.distance) begin
        best.label    = CL_W'(c);
        best.distance = dist_sum[c];
      end
    end
    for (int c = 0; c < MAX_CLUSTERS; c++) dist_sum[c] = '0;
    expected_assignments.push_back(best);
  endtask

  always @(posedge clk) begin
    assignment_t want;
    if (!rst_n) begin
      for (int c = 0; c < MAX_CLUSTERS; c++) dist_sum[c] = '0;
      clusters_reg = AC_W'(MAX_CLUSTERS);
      length_reg   = VL_W'(MAX_DIM);
      expected_assignments.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (expected_assignments.size() == 0) begin
          $error("unexpected result transaction: nearest_label %0d, best_distance %0d",
                 out_mon.nearest_label, out_mon.best_distance);
          fail_count++;
        end else begin
          want = expected_assignments.pop_front();
          if (out_mon.nearest_label !== want.label) begin
            $error("nearest_label: expected %0d, actual %0d", want.label,
                   out_mon.nearest_label);
            fail_count++;
          end
          if (out_mon.best_distance !== want.distance) begin
            $error("best_distance: expected %0d, actual %0d", want.distance,
                   out_mon.best_distance);
            fail_count++;
          end
        end
      end
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        case (cfg_mon.reg_index)
          REG_ACTIVE_CLUSTERS: clusters_reg = AC_W'(cfg_mon.wdata);
          REG_VECTOR_LENGTH:   length_reg = VL_W'(cfg_mon.wdata);
          default: ;
        endcase
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        apply_element(in_mon.opcode, in_mon.cluster_index, in_mon.element_index,
                      in_mon.element_value);
      end
    end
    pending_count = expected_assignments.size();
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Nearest centroid assignment testbench
// Loads centroid tables and streams query vectors into the core under several
// cluster counts and vector lengths, with random gaps on both sides, a long
// result back-pressure stretch and drain pauses. The monitor predicts and
// checks every assignment; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nca_pkg::*;

  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  nca_in_if  elem_chan ();
  nca_out_if result_chan ();
  nca_cfg_if reg_chan ();

  int fail_count;
  int pending_count;

  nearest_centroid_assign_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (elem_chan),
    .out_chan (result_chan),
    .cfg_chan (reg_chan)
  );

  nca_assign_monitor assign_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (elem_chan),
    .out_mon       (result_chan),
    .cfg_mon       (reg_chan),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  int        send_idle_pct = 28;
  int        recv_idle_pct = 53;
  bit        hold_req      = 1'b0;
  int        hold_left     = 0;
  int        quiet_cycles  = 0;
  int        items_sent    = 0;
  int        active_k      = MAX_CLUSTERS;
  int        active_len    = MAX_DIM;
  bit        centroid_loaded[MAX_CLUSTERS][MAX_DIM];
  nca_elem_t centroid_shadow[MAX_CLUSTERS][MAX_DIM];

  initial begin
    result_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_chan.ready = 1'b0;
      end else begin
        result_chan.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((elem_chan.valid === 1'b1 && elem_chan.ready === 1'b1) ||
        (result_chan.valid === 1'b1 && result_chan.ready === 1'b1) ||
        (reg_chan.valid === 1'b1 && reg_chan.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic nca_elem_t random_element();
    case ($urandom_range(7))
      0: return nca_elem_t'(-32768);
      1: return nca_elem_t'(32767);
      2: return '0;
      default: return nca_elem_t'($urandom);
    endcase
  endfunction

  function automatic nca_elem_t near_element(nca_elem_t base);
    int v;
    v = int'(base) + int'($urandom_range(64)) - 32;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return nca_elem_t'(v);
  endfunction

  task automatic send_item(logic op, logic [CL_W-1:0] ci, logic [DIM_W-1:0] ei,
                           nca_elem_t value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      elem_chan.valid = 1'b0;
      @(negedge clk);
    end
    elem_chan.valid         = 1'b1;
    elem_chan.opcode        = op;
    elem_chan.cluster_index = ci;
    elem_chan.element_index = ei;
    elem_chan.element_value = value;
    do @(posedge clk); while (elem_chan.ready !== 1'b1);
    if (op == OP_LOAD) begin
      centroid_loaded[ci][ei] = 1'b1;
      centroid_shadow[ci][ei] = value;
    end
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int raw;
    @(negedge clk);
    reg_chan.valid     = 1'b1;
    reg_chan.reg_index = idx;
    reg_chan.wdata     = data;
    do @(posedge clk); while (reg_chan.ready !== 1'b1);
    @(negedge clk);
    reg_chan.valid = 1'b0;
    case (idx)
      REG_ACTIVE_CLUSTERS: begin
        raw      = int'(data) & 31;
        active_k = (raw == 0) ? 1 : (raw > MAX_CLUSTERS) ? MAX_CLUSTERS : raw;
      end
      REG_VECTOR_LENGTH: begin
        raw        = int'(data) & 127;
        active_len = (raw == 0) ? 1 : (raw > MAX_DIM) ? MAX_DIM : raw;
      end
      default: ;
    endcase
  endtask

  task automatic wait_results();
    @(negedge clk);
    elem_chan.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic fill_table();
    for (int c = 0; c < active_k; c++) begin
      for (int e = 0; e < active_len; e++) begin
        if (!centroid_loaded[c][e]) send_item(OP_LOAD, CL_W'(c), DIM_W'(e), random_element());
      end
    end
  endtask

  task automatic send_query();
    bit        near;
    int        target;
    nca_elem_t value;
    near   = $urandom_range(1);
    target = $urandom_range(active_k - 1);
    for (int e = 0; e < active_len; e++) begin
      value = near ? near_element(centroid_shadow[target][e]) : random_element();
      send_item(OP_QUERY, CL_W'($urandom), DIM_W'(e), value);
    end
  endtask

  task automatic send_broken();
    int n;
    case ($urandom_range(3))
      0: begin
        n = $urandom_range(active_len - 1);
        for (int e = 0; e < n; e++) begin
          send_item(OP_QUERY, CL_W'($urandom), DIM_W'(e), random_element());
        end
      end
      1: send_item(OP_QUERY, CL_W'($urandom), DIM_W'($urandom_range(active_len - 1)),
                   random_element());
      2: send_item(OP_QUERY, CL_W'($urandom),
                   DIM_W'($urandom_range(MAX_DIM - 1, active_len - 1)), random_element());
      default: send_item(OP_LOAD, CL_W'($urandom), DIM_W'($urandom), random_element());
    endcase
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] k_raw, logic [CFG_DATA_W-1:0] len_raw,
                           int budget, bit hold_results);
    int stop;
    write_reg(REG_ACTIVE_CLUSTERS, k_raw);
    write_reg(REG_VECTOR_LENGTH, len_raw);
    fill_table();
    if (hold_results) hold_req = 1'b1;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      if ($urandom_range(99) < 80) send_query();
      else send_broken();
      if ($urandom_range(29) == 0) wait_results();
    end
    wait_idle();
  endtask

  task automatic run_directed();
    nca_elem_t level;
    write_reg(REG_ACTIVE_CLUSTERS, 4);
    write_reg(REG_VECTOR_LENGTH, 3);
    for (int c = 0; c < 4; c++) begin
      level = (c == 0) ? nca_elem_t'(32767) : (c == 1) ? nca_elem_t'(-32768) : '0;
      for (int e = 0; e < 3; e++) send_item(OP_LOAD, CL_W'(c), DIM_W'(e), level);
    end
    send_item(OP_LOAD, CL_W'(15), DIM_W'(63), nca_elem_t'(-1));
    for (int e = 0; e < 3; e++) send_item(OP_QUERY, CL_W'(15), DIM_W'(e), nca_elem_t'(-32768));
    // Centroids two and three are equal, so the lower index must win.
    for (int e = 0; e < 3; e++) send_item(OP_QUERY, CL_W'(0), DIM_W'(e), '0);
    send_item(OP_QUERY, CL_W'(0), DIM_W'(0), nca_elem_t'(5));
    send_item(OP_QUERY, CL_W'(0), DIM_W'(63), nca_elem_t'(7));
    send_item(OP_QUERY, CL_W'(0), DIM_W'(0), nca_elem_t'(-32768));
    send_item(OP_QUERY, CL_W'(9), DIM_W'(2), nca_elem_t'(32767));
    send_item(OP_QUERY, CL_W'(0), DIM_W'(1), nca_elem_t'(100));
    wait_idle();
  endtask

  initial begin
    elem_chan.valid         = 1'b0;
    elem_chan.opcode        = OP_LOAD;
    elem_chan.cluster_index = '0;
    elem_chan.element_index = '0;
    elem_chan.element_value = '0;
    reg_chan.valid          = 1'b0;
    reg_chan.reg_index      = '0;
    reg_chan.wdata          = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
    run_phase(31, 8, 220, 1'b0);

    send_idle_pct = 53;
    recv_idle_pct = 28;
    run_phase(0, 0, 180, 1'b1);
    run_phase(2, 127, 260, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(7, 5, 220, 1'b0);
    run_phase(16, 16, 220, 1'b0);

    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
